>>> sv/lsf_pkg.sv
`timescale 1ns / 1ps

package lsf_pkg;

	// fixed field widths
	localparam int COORD_W = 16;
	localparam int FRAC_W = 16;
	localparam int OUT_W = 48;

	// status codes
	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_FEW = 2'd1;
	localparam logic [1:0] ST_ZERO = 2'd2;
	localparam logic [1:0] ST_DROP = 2'd3;

	// one fit result
	typedef struct packed {
		logic [OUT_W-1:0] slope;
		logic [OUT_W-1:0] offset;
		logic [1:0] status;
	} fit_res_t;

endpackage

>>> sv/least_squares_line_fit_top.sv
`timescale 1ns / 1ps
// points are taken one per cycle while no fit is running
// a point flagged last starts the fit: six serial multiplies and two
// restoring divisions on one shared wide adder; a set of fewer than two
// points skips them
// asynchronous active-low reset clears all sums, the mode register and the sequencer

module least_squares_line_fit_top #(
	parameter int MAX_POINTS = 4096
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic cfg_data,
	input logic in_valid,
	output logic in_stall,
	input logic signed [lsf_pkg::COORD_W-1:0] x_coord,
	input logic signed [lsf_pkg::COORD_W-1:0] y_coord,
	input logic last,
	output logic out_valid,
	input logic out_stall,
	output logic signed [lsf_pkg::OUT_W-1:0] slope_term,
	output logic signed [lsf_pkg::OUT_W-1:0] offset_term,
	output logic [1:0] status
);
	import lsf_pkg::*;

	localparam int CNT_W = $clog2(MAX_POINTS+1);
	localparam int SUM_W = COORD_W + CNT_W;
	localparam int PROD_W = 2*COORD_W + CNT_W;

	logic mode_q;
	logic take, idle, clear, dropped;
	logic [CNT_W-1:0] count;
	logic signed [SUM_W-1:0] sum_x, sum_y;
	logic signed [PROD_W-1:0] sum_xy;
	logic [PROD_W-1:0] sum_square;
	fit_res_t res;

	// mode register
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			mode_q <= cfg_data;
		end
	end

	// input transaction
	assign in_stall = !idle;
	assign take = in_valid && !in_stall;

	lsf_accum #(.MAX_POINTS(MAX_POINTS)) u_accum (
		.clk(clk),
		.arst_n(arst_n),
		.take(take),
		.clear(clear),
		.fit_mode(mode_q),
		.x_coord(x_coord),
		.y_coord(y_coord),
		.count(count),
		.sum_x(sum_x),
		.sum_y(sum_y),
		.sum_xy(sum_xy),
		.sum_square(sum_square),
		.dropped(dropped)
	);

	lsf_fit #(.MAX_POINTS(MAX_POINTS)) u_fit (
		.clk(clk),
		.arst_n(arst_n),
		.start(take && last),
		.fit_mode(mode_q),
		.count(count),
		.sum_x(sum_x),
		.sum_y(sum_y),
		.sum_xy(sum_xy),
		.sum_square(sum_square),
		.dropped(dropped),
		.idle(idle),
		.clear(clear),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.res(res)
	);

	assign slope_term = res.slope;
	assign offset_term = res.offset;
	assign status = res.status;

endmodule

>>> sv/lsf_alu.sv
`timescale 1ns / 1ps

module lsf_alu #(
	parameter int WIDTH = 92
) (
	input logic [WIDTH-1:0] a,
	input logic [WIDTH-1:0] b,
	input logic sub,
	output logic [WIDTH-1:0] res,
	output logic borrow
);
	logic [WIDTH:0] full;

	// shared wide add / subtract, top bit is the borrow on subtract
	always_comb begin
		if (sub) begin
			full = {1'b0, a} - {1'b0, b};
		end else begin
			full = {1'b0, a} + {1'b0, b};
		end
	end

	assign res = full[WIDTH-1:0];
	assign borrow = full[WIDTH];

endmodule

>>> sv/lsf_accum.sv
`timescale 1ns / 1ps

module lsf_accum #(
	parameter int MAX_POINTS = 4096
) (
	input logic clk,
	input logic arst_n,
	input logic take,
	input logic clear,
	input logic fit_mode,
	input logic signed [lsf_pkg::COORD_W-1:0] x_coord,
	input logic signed [lsf_pkg::COORD_W-1:0] y_coord,
	output logic [$clog2(MAX_POINTS+1)-1:0] count,
	output logic signed [lsf_pkg::COORD_W+$clog2(MAX_POINTS+1)-1:0] sum_x,
	output logic signed [lsf_pkg::COORD_W+$clog2(MAX_POINTS+1)-1:0] sum_y,
	output logic signed [2*lsf_pkg::COORD_W+$clog2(MAX_POINTS+1)-1:0] sum_xy,
	output logic [2*lsf_pkg::COORD_W+$clog2(MAX_POINTS+1)-1:0] sum_square,
	output logic dropped
);
	import lsf_pkg::*;

	localparam int CNT_W = $clog2(MAX_POINTS+1);
	localparam int SUM_W = COORD_W + CNT_W;
	localparam int PROD_W = 2*COORD_W + CNT_W;

	logic [CNT_W-1:0] count_q;
	logic signed [SUM_W-1:0] sum_x_q, sum_y_q;
	logic signed [PROD_W-1:0] sum_xy_q;
	logic [PROD_W-1:0] sum_sq_q;
	logic dropped_q;
	logic signed [2*COORD_W-1:0] xy_prod, uu_prod;
	logic signed [COORD_W-1:0] u_coord;
	logic room;

	// per point products
	assign u_coord = fit_mode ? y_coord : x_coord;
	assign xy_prod = x_coord * y_coord;
	assign uu_prod = u_coord * u_coord;
	assign room = count_q < CNT_W'(MAX_POINTS);

	// running sums, cleared once the fit is delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			sum_x_q <= '0;
			sum_y_q <= '0;
			sum_xy_q <= '0;
			sum_sq_q <= '0;
			dropped_q <= 1'b0;
		end else if (clear) begin
			count_q <= '0;
			sum_x_q <= '0;
			sum_y_q <= '0;
			sum_xy_q <= '0;
			sum_sq_q <= '0;
			dropped_q <= 1'b0;
		end else if (take) begin
			if (room) begin
				count_q <= count_q + CNT_W'(1);
				sum_x_q <= sum_x_q + SUM_W'(x_coord);
				sum_y_q <= sum_y_q + SUM_W'(y_coord);
				sum_xy_q <= sum_xy_q + PROD_W'(xy_prod);
				sum_sq_q <= sum_sq_q + PROD_W'(unsigned'(uu_prod));
			end else begin
				dropped_q <= 1'b1;
			end
		end
	end

	assign count = count_q;
	assign sum_x = sum_x_q;
	assign sum_y = sum_y_q;
	assign sum_xy = sum_xy_q;
	assign sum_square = sum_sq_q;
	assign dropped = dropped_q;

endmodule

>>> sv/lsf_fit.sv
`timescale 1ns / 1ps

module lsf_fit #(
	parameter int MAX_POINTS = 4096
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic fit_mode,
	input logic [$clog2(MAX_POINTS+1)-1:0] count,
	input logic signed [lsf_pkg::COORD_W+$clog2(MAX_POINTS+1)-1:0] sum_x,
	input logic signed [lsf_pkg::COORD_W+$clog2(MAX_POINTS+1)-1:0] sum_y,
	input logic signed [2*lsf_pkg::COORD_W+$clog2(MAX_POINTS+1)-1:0] sum_xy,
	input logic [2*lsf_pkg::COORD_W+$clog2(MAX_POINTS+1)-1:0] sum_square,
	input logic dropped,
	output logic idle,
	output logic clear,
	output logic out_valid,
	input logic out_stall,
	output lsf_pkg::fit_res_t res
);
	import lsf_pkg::*;

	localparam int CNT_W = $clog2(MAX_POINTS+1);
	localparam int SUM_W = COORD_W + CNT_W;
	localparam int PROD_W = 2*COORD_W + CNT_W;
	localparam int A_W = SUM_W + PROD_W + FRAC_W + 2;
	localparam int STEP_W = $clog2(A_W);
	localparam logic [A_W-1:0] LIM_A = A_W'(1) << (OUT_W-1);
	localparam logic [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
	localparam logic [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_START = 4'd1;
	localparam logic [3:0] S_MLOAD = 4'd2;
	localparam logic [3:0] S_MUL = 4'd3;
	localparam logic [3:0] S_TERM = 4'd4;
	localparam logic [3:0] S_DNEG = 4'd5;
	localparam logic [3:0] S_NNEG = 4'd6;
	localparam logic [3:0] S_DIV = 4'd7;
	localparam logic [3:0] S_SAT = 4'd8;
	localparam logic [3:0] S_DONE = 4'd9;

	localparam logic [2:0] P_DET_B = 3'd1;
	localparam logic [2:0] P_SLOPE_B = 3'd3;
	localparam logic [2:0] P_OFFS_A = 3'd4;

	logic [3:0] state_q;
	logic [2:0] pidx_q;
	logic [STEP_W-1:0] cnt_q;
	logic [A_W-1:0] acc_q, mcand_q, det_q, rem_q, quo_q;
	logic [SUM_W-1:0] mult_q;
	logic msub_q, det_neg_q, num_neg_q;
	logic [OUT_W-1:0] slope_q, offset_q;
	logic [1:0] status_q;

	logic signed [SUM_W-1:0] su, sv, mult_sel;
	logic [A_W-1:0] mcand_sel, alu_a, alu_b, alu_res, div_sh, num_mag;
	logic sub_sel, mult_neg, alu_sub, alu_borrow;
	logic [OUT_W-1:0] sat_val;

	// fitted-along and other coordinate sums
	assign su = fit_mode ? sum_y : sum_x;
	assign sv = fit_mode ? sum_x : sum_y;

	// operands of each partial term: det, slope numerator, offset numerator
	always_comb begin
		unique case (pidx_q)
			3'd0: begin
				mult_sel = SUM_W'(count);
				mcand_sel = A_W'(sum_square);
				sub_sel = 1'b0;
			end
			3'd1: begin
				mult_sel = su;
				mcand_sel = A_W'(su);
				sub_sel = 1'b1;
			end
			3'd2: begin
				mult_sel = su;
				mcand_sel = A_W'(sv);
				sub_sel = 1'b0;
			end
			3'd3: begin
				mult_sel = SUM_W'(count);
				mcand_sel = A_W'(sum_xy);
				sub_sel = 1'b1;
			end
			3'd4: begin
				mult_sel = su;
				mcand_sel = A_W'(sum_xy);
				sub_sel = 1'b0;
			end
			3'd5: begin
				mult_sel = sv;
				mcand_sel = A_W'(sum_square);
				sub_sel = 1'b1;
			end
			default: begin
				mult_sel = '0;
				mcand_sel = '0;
				sub_sel = 1'b0;
			end
		endcase
	end
	assign mult_neg = mult_sel[SUM_W-1];

	// shared adder input selection
	assign div_sh = {rem_q[A_W-2:0], quo_q[A_W-1]};
	always_comb begin
		unique case (state_q)
			S_MUL: begin
				alu_a = acc_q;
				alu_b = mcand_q;
				alu_sub = msub_q;
			end
			S_DNEG: begin
				alu_a = '0;
				alu_b = det_q;
				alu_sub = 1'b1;
			end
			S_NNEG: begin
				alu_a = '0;
				alu_b = acc_q;
				alu_sub = 1'b1;
			end
			S_DIV: begin
				alu_a = div_sh;
				alu_b = det_q;
				alu_sub = 1'b1;
			end
			default: begin
				alu_a = acc_q;
				alu_b = mcand_q;
				alu_sub = 1'b0;
			end
		endcase
	end

	lsf_alu #(.WIDTH(A_W)) u_alu (
		.a(alu_a),
		.b(alu_b),
		.sub(alu_sub),
		.res(alu_res),
		.borrow(alu_borrow)
	);

	assign num_mag = num_neg_q ? alu_res : acc_q;

	// quotient saturation to the output range
	always_comb begin
		if (num_neg_q ^ det_neg_q) begin
			sat_val = (quo_q > LIM_A) ? OUT_MIN : (~quo_q[OUT_W-1:0] + OUT_W'(1));
		end else begin
			sat_val = (quo_q > (LIM_A - A_W'(1))) ? OUT_MAX : quo_q[OUT_W-1:0];
		end
	end

	// control sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pidx_q <= '0;
			cnt_q <= '0;
			msub_q <= 1'b0;
			det_neg_q <= 1'b0;
			num_neg_q <= 1'b0;
			status_q <= ST_OK;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_START;
					end
				end
				S_START: begin
					pidx_q <= '0;
					if (count < CNT_W'(2)) begin
						status_q <= ST_FEW;
						state_q <= S_DONE;
					end else begin
						state_q <= S_MLOAD;
					end
				end
				S_MLOAD: begin
					msub_q <= sub_sel ^ mult_neg;
					cnt_q <= '0;
					state_q <= S_MUL;
				end
				S_MUL: begin
					cnt_q <= cnt_q + STEP_W'(1);
					if (cnt_q == STEP_W'(SUM_W-1)) begin
						if (pidx_q[0]) begin
							state_q <= S_TERM;
						end else begin
							pidx_q <= pidx_q + 3'd1;
							state_q <= S_MLOAD;
						end
					end
				end
				S_TERM: begin
					if (pidx_q == P_DET_B) begin
						det_neg_q <= acc_q[A_W-1];
						if (acc_q == '0) begin
							status_q <= ST_ZERO;
							state_q <= S_DONE;
						end else begin
							state_q <= S_DNEG;
						end
					end else begin
						num_neg_q <= acc_q[A_W-1];
						state_q <= S_NNEG;
					end
				end
				S_DNEG: begin
					pidx_q <= 3'd2;
					state_q <= S_MLOAD;
				end
				S_NNEG: begin
					cnt_q <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					cnt_q <= cnt_q + STEP_W'(1);
					if (cnt_q == STEP_W'(A_W-1)) begin
						state_q <= S_SAT;
					end
				end
				S_SAT: begin
					if (pidx_q == P_SLOPE_B) begin
						pidx_q <= P_OFFS_A;
						state_q <= S_MLOAD;
					end else begin
						status_q <= dropped ? ST_DROP : ST_OK;
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (!out_stall) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_START: begin
				slope_q <= '0;
				offset_q <= '0;
			end
			S_MLOAD: begin
				mult_q <= mult_neg ? (~mult_sel + SUM_W'(1)) : mult_sel;
				mcand_q <= mcand_sel;
				if (!pidx_q[0]) begin
					acc_q <= '0;
				end
			end
			S_MUL: begin
				if (mult_q[0]) begin
					acc_q <= alu_res;
				end
				mcand_q <= {mcand_q[A_W-2:0], 1'b0};
				mult_q <= {1'b0, mult_q[SUM_W-1:1]};
			end
			S_TERM: begin
				if (pidx_q == P_DET_B) begin
					det_q <= acc_q;
				end
			end
			S_DNEG: begin
				if (det_neg_q) begin
					det_q <= alu_res;
				end
			end
			S_NNEG: begin
				quo_q <= num_mag << FRAC_W;
				rem_q <= '0;
			end
			S_DIV: begin
				rem_q <= alu_borrow ? div_sh : alu_res;
				quo_q <= {quo_q[A_W-2:0], ~alu_borrow};
			end
			S_SAT: begin
				if (pidx_q == P_SLOPE_B) begin
					slope_q <= sat_val;
				end else begin
					offset_q <= sat_val;
				end
			end
			default: begin
			end
		endcase
	end

	assign idle = state_q == S_IDLE;
	assign out_valid = state_q == S_DONE;
	assign clear = out_valid && !out_stall;
	assign res.slope = slope_q;
	assign res.offset = offset_q;
	assign res.status = status_q;

	// checks
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> state_q == S_IDLE) else $error("fit started while busy");
	a_div_den: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV |-> det_q != '0) else $error("division by zero determinant");
	a_zero_res: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status_q == ST_FEW || status_q == ST_ZERO)
		|-> slope_q == '0 && offset_q == '0) else $error("nonzero terms on failed fit");
	a_clear_idle: assert property (@(posedge clk) disable iff (!arst_n)
		clear |=> state_q == S_IDLE) else $error("not idle after delivery");

endmodule

>>> dv/tb_least_squares_line_fit_top.sv
`timescale 1ns / 1ps

module tb_least_squares_line_fit_top;
	import lsf_pkg::*;

	localparam int CAPACITY = 4096;
	localparam int FIT_CYCLES = 400;
	localparam int HOLD_CYCLES = 2000;
	localparam int IDLE_LIMIT = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic cfg_data = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [COORD_W-1:0] x_coord = '0;
	logic signed [COORD_W-1:0] y_coord = '0;
	logic last = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [OUT_W-1:0] slope_term;
	logic signed [OUT_W-1:0] offset_term;
	logic [1:0] status;

	least_squares_line_fit_top dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.x_coord(x_coord), .y_coord(y_coord), .last(last),
		.out_valid(out_valid), .out_stall(out_stall),
		.slope_term(slope_term), .offset_term(offset_term), .status(status)
	);

	// clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// shadow of the fit state
	logic mode_copy = 1'b0;
	int unsigned pts_held = 0;
	longint acc_x = 0, acc_y = 0, acc_xy = 0, acc_sq = 0;
	bit pts_lost = 1'b0;

	fit_res_t fit_queue[$];
	int errors = 0;
	int idle_cycles = 0;
	int items_sent = 0;
	bit hold_req = 1'b0;
	bit typed_on = 1'b0;
	fit_res_t typed_fit;
	int burst_left = 0;
	bit no_gaps = 1'b0;

	function automatic logic [OUT_W-1:0] clamp_q(logic signed [191:0] q);
		logic signed [191:0] hi, lo;
		hi = (192'sd1 <<< (OUT_W-1)) - 1;
		lo = -(192'sd1 <<< (OUT_W-1));
		if (q > hi) return hi[OUT_W-1:0];
		if (q < lo) return lo[OUT_W-1:0];
		return q[OUT_W-1:0];
	endfunction

	// accumulate one point, close the set on last
	function automatic bit fit_point(logic signed [COORD_W-1:0] px,
			logic signed [COORD_W-1:0] py, logic pl, output fit_res_t res);
		longint u;
		logic signed [191:0] n, su, sv, sq, sxy, det, ns, no;
		res = '0;
		if (pts_held < CAPACITY) begin
			u = mode_copy ? longint'(py) : longint'(px);
			acc_x += px;
			acc_y += py;
			acc_xy += longint'(px) * longint'(py);
			acc_sq += u * u;
			pts_held++;
		end else
			pts_lost = 1'b1;
		if (!pl) return 1'b0;
		n = pts_held;
		su = mode_copy ? acc_y : acc_x;
		sv = mode_copy ? acc_x : acc_y;
		sq = acc_sq;
		sxy = acc_xy;
		if (pts_held < 2)
			res.status = ST_FEW;
		else begin
			det = n * sq - su * su;
			if (det == 0)
				res.status = ST_ZERO;
			else begin
				ns = (su * sv - n * sxy) <<< FRAC_W;
				no = (su * sxy - sv * sq) <<< FRAC_W;
				res.slope = clamp_q(ns / det);
				res.offset = clamp_q(no / det);
				res.status = pts_lost ? ST_DROP : ST_OK;
			end
		end
		pts_held = 0;
		acc_x = 0; acc_y = 0; acc_xy = 0; acc_sq = 0;
		pts_lost = 1'b0;
		return 1'b1;
	endfunction

	task automatic report(string what, logic [OUT_W-1:0] got, logic [OUT_W-1:0] want);
		$display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	// input monitor and predictor
	always @(posedge clk) begin
		fit_res_t r;
		if (in_valid && !in_stall) begin
			if (fit_point(x_coord, y_coord, last, r))
				fit_queue.push_back(typed_on ? typed_fit : r);
		end
	end

	// output checker
	always @(posedge clk) begin
		fit_res_t w;
		if (out_valid && !out_stall) begin
			if (fit_queue.size() == 0)
				report("unexpected transaction", slope_term, '0);
			else begin
				w = fit_queue.pop_front();
				if (slope_term !== w.slope) report("slope_term", slope_term, w.slope);
				if (offset_term !== w.offset) report("offset_term", offset_term, w.offset);
				if (status !== w.status) report("status", status, w.status);
			end
		end
	end

	// watchdog on cycles with no transaction
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > IDLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// receiver stall pattern, with a long hold when requested
	initial begin
		int pat, left;
		pat = 0;
		left = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
			end
			if (left == 0) begin
				pat = $urandom_range(0, 2);
				left = $urandom_range(16, 96);
			end
			left--;
			case (pat)
				0: out_stall <= 1'b0;
				1: out_stall <= ($urandom_range(0, 2) == 0);
				default: out_stall <= ($urandom_range(0, 3) != 0);
			endcase
		end
	end

	task automatic push_point(logic signed [COORD_W-1:0] px, logic signed [COORD_W-1:0] py,
			logic pl);
		if (burst_left == 0 && !no_gaps) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat ($urandom_range(0, 6)) @(negedge clk);
			burst_left = $urandom_range(1, 20);
		end else
			@(negedge clk);
		if (burst_left > 0) burst_left--;
		in_valid <= 1'b1;
		x_coord <= px;
		y_coord <= py;
		last <= pl;
		items_sent++;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic idle_input;
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	function automatic logic [COORD_W-1:0] pick_coord(int kind);
		case (kind)
			0: return COORD_W'($urandom());
			1: return COORD_W'($urandom_range(0, 15) - 8);
			default: return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
		endcase
	endfunction

	// one set of points; flat puts every point on the same fitted-along value
	task automatic send_set(int count, int kind, bit flat, bit close);
		logic [COORD_W-1:0] fixed_u, a, b;
		fixed_u = pick_coord(kind);
		for (int i = 0; i < count; i++) begin
			a = pick_coord(($urandom_range(0, 9) == 0) ? 2 : kind);
			b = pick_coord(($urandom_range(0, 9) == 0) ? 2 : kind);
			if (flat) a = fixed_u;
			if (mode_copy) push_point(b, a, close && i == count - 1);
			else push_point(a, b, close && i == count - 1);
		end
	endtask

	task automatic write_mode(logic m);
		idle_input();
		wait (fit_queue.size() == 0);
		repeat (FIT_CYCLES) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= m;
		do @(posedge clk); while (!cfg_ready);
		mode_copy = m;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	typedef struct {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic l;
		bit typed;
		logic [1:0] st;
	} point_row_t;

	// directed points in x mode; typed rows have zero terms
	point_row_t points_tbl[] = '{
		'{16'h7fff, 16'h8000, 1'b1, 1'b1, ST_FEW},
		'{16'h8000, 16'h7fff, 1'b1, 1'b1, ST_FEW},
		'{16'h0000, 16'h0000, 1'b1, 1'b1, ST_FEW},
		'{16'h8000, 16'h8000, 1'b0, 1'b0, ST_OK},
		'{16'h8000, 16'h7fff, 1'b1, 1'b1, ST_ZERO},
		'{16'h7fff, 16'h7fff, 1'b0, 1'b0, ST_OK},
		'{16'h7fff, 16'h0001, 1'b0, 1'b0, ST_OK},
		'{16'h7fff, 16'h8000, 1'b1, 1'b1, ST_ZERO},
		'{16'h0000, 16'h8000, 1'b0, 1'b0, ST_OK},
		'{16'h0001, 16'h7fff, 1'b1, 1'b0, ST_OK},
		'{16'h7fff, 16'h7fff, 1'b0, 1'b0, ST_OK},
		'{16'h8000, 16'h8000, 1'b1, 1'b0, ST_OK},
		'{16'h0003, 16'hfffe, 1'b0, 1'b0, ST_OK},
		'{16'hffff, 16'h0005, 1'b0, 1'b0, ST_OK},
		'{16'h0002, 16'h0000, 1'b0, 1'b0, ST_OK},
		'{16'h7fff, 16'h8000, 1'b1, 1'b0, ST_OK},
		'{16'h8000, 16'h0000, 1'b0, 1'b0, ST_OK},
		'{16'h7fff, 16'hffff, 1'b0, 1'b0, ST_OK},
		'{16'h0000, 16'h7fff, 1'b1, 1'b0, ST_OK}
	};

	// main sequence
	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed part; expectation changes land after the monitor has sampled
		foreach (points_tbl[i]) begin
			typed_fit <= '{slope: '0, offset: '0, status: points_tbl[i].st};
			typed_on <= points_tbl[i].typed;
			push_point(points_tbl[i].x, points_tbl[i].y, points_tbl[i].l);
		end
		typed_on <= 1'b0;

		// random phases in both modes
		for (int ph = 0; ph < 8; ph++) begin
			write_mode(ph[0]);
			no_gaps = (ph == 3);
			if (ph == 2) begin
				// long receiver hold while the sender keeps going
				hold_req = 1'b1;
				for (int k = 0; k < 6; k++) send_set($urandom_range(2, 5), 1, 1'b0, 1'b1);
				idle_input();
				wait (fit_queue.size() == 0);
			end
			for (int k = 0; k < 28; k++) begin
				int n, kind;
				n = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 6);
				kind = $urandom_range(0, 2);
				send_set(n, kind, $urandom_range(0, 9) == 0, 1'b1);
			end
			// leave a set open across the mode change now and then
			if (ph[0] == 1'b0) send_set($urandom_range(1, 3), 0, 1'b0, 1'b0);
		end
		while (items_sent < 850) begin
			int n;
			n = $urandom_range(2, 6);
			send_set(n, $urandom_range(0, 1), 1'b0, 1'b1);
		end

		idle_input();
		wait (fit_queue.size() == 0);
		repeat (FIT_CYCLES) @(posedge clk);
		if (errors == 0 && fit_queue.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
